/* sv/saturating_int32_alu_core_defines.svh */
// Assertion macros shared by the saturating ALU core.
`ifndef SATURATING_INT32_ALU_CORE_DEFINES_SVH
`define SATURATING_INT32_ALU_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SIA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sia core: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SIA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sia core: next-cycle check failed");

`endif

/* sv/sia_pkg.sv */
`timescale 1ns / 1ps
package sia_pkg;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_MUL    = 3'd2,
      CMD_DIV    = 3'd3,
      CMD_NARROW = 3'd4,
      CMD_SUM    = 3'd5
   } cmd_type;

   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] INT_MIN = 32'h8000_0000;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = 32;

   // word riding alongside the divider
   typedef struct packed {
      logic [31:0] fast_result; // result for every command but divide
      logic        is_null;
      logic        is_div;
      logic        div_zero;
      logic        negate;      // quotient sign
   } carry_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvd;         // dividend shifting out, quotient shifting in
      logic [31:0] dsr;
   } div_type;

   // clamp a 33-bit sum to int32
   function automatic logic [31:0] sat33(input logic [32:0] s);
      logic [31:0] r;
      if (s[32] == s[31]) r = s[31:0];
      else if (s[32]) r = INT_MIN;
      else r = INT_MAX;
      return r;
   endfunction

   // clamp a 64-bit value to int32
   function automatic logic [31:0] sat64(input logic [63:0] w);
      logic [31:0] r;
      if (w[63:31] == {33{w[31]}}) r = w[31:0];
      else if (w[63]) r = INT_MIN;
      else r = INT_MAX;
      return r;
   endfunction

endpackage

/* sv/saturating_int32_alu_core.sv */
`timescale 1ns / 1ps
// Path: the accepting edge loads stage A; the word then passes stages B and C, the divider and the output register.
// Throughput: one word per cycle; busy is always low, the pipeline never stalls.
// Depth is set by the divider: a 32-stage restoring array, one quotient bit a stage.
// Reset (synchronous, active high) clears every stage valid bit; payload is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "saturating_int32_alu_core_defines.svh"
module saturating_int32_alu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [63:0] req_wide_value,
   input  logic               req_a_is_null,
   input  logic               req_b_is_null,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result,
   output logic               rsp_result_is_null,
   output logic               rsp_status
);

   // Pipeline never holds, so new words are always welcome.
   assign busy = 1'b0;

   // ---------------- stage A: input register ----------------
   logic               a_vld_ff;
   logic [2:0]         a_cmd_ff;
   logic signed [31:0] a_opa_ff, a_opb_ff;
   logic signed [63:0] a_wide_ff;
   logic               a_an_ff, a_bn_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else a_vld_ff <= start && !busy;
      a_cmd_ff  <= req_cmd;
      a_opa_ff  <= req_operand_a;
      a_opb_ff  <= req_operand_b;
      a_wide_ff <= req_wide_value;
      a_an_ff   <= req_a_is_null;
      a_bn_ff   <= req_b_is_null;
   end

   // ---------------- stage B: add/sub/narrow, multiply, divider prep ----------------
   logic [32:0]        b_sum_in, b_diff_in;
   logic [31:0]        b_res_in;
   logic               b_null_in;
   logic signed [63:0] b_prod_in;
   logic [31:0]        b_abs_a_in, b_abs_b_in;

   always_comb begin
      b_sum_in  = {a_opa_ff[31], a_opa_ff} + {a_opb_ff[31], a_opb_ff};
      b_diff_in = {a_opa_ff[31], a_opa_ff} - {a_opb_ff[31], a_opb_ff};
      b_prod_in = a_opa_ff * a_opb_ff;
      b_abs_a_in = a_opa_ff[31] ? (~a_opa_ff + 32'd1) : a_opa_ff;
      b_abs_b_in = a_opb_ff[31] ? (~a_opb_ff + 32'd1) : a_opb_ff;
      b_null_in = 1'b0;
      case (a_cmd_ff)
         sia_pkg::CMD_ADD:    b_res_in = sia_pkg::sat33(b_sum_in);
         sia_pkg::CMD_SUB:    b_res_in = sia_pkg::sat33(b_diff_in);
         sia_pkg::CMD_NARROW: b_res_in = sia_pkg::sat64(a_wide_ff);
         sia_pkg::CMD_SUM: begin
            if (a_an_ff && a_bn_ff) begin
               b_res_in  = 32'd0;
               b_null_in = 1'b1;
            end else if (a_an_ff) b_res_in = a_opb_ff;
            else if (a_bn_ff) b_res_in = a_opa_ff;
            else b_res_in = sia_pkg::sat33(b_sum_in);
         end
         default:             b_res_in = 32'd0; // multiply resolved next stage
      endcase
   end

   logic               b_vld_ff;
   logic [2:0]         b_cmd_ff;
   logic [31:0]        b_res_ff;
   logic               b_null_ff;
   logic signed [63:0] b_prod_ff;
   logic [31:0]        b_abs_a_ff, b_abs_b_ff;
   logic               b_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else b_vld_ff <= a_vld_ff;
      b_cmd_ff   <= a_cmd_ff;
      b_res_ff   <= b_res_in;
      b_null_ff  <= b_null_in;
      b_prod_ff  <= b_prod_in;
      b_abs_a_ff <= b_abs_a_in;
      b_abs_b_ff <= b_abs_b_in;
      b_neg_ff   <= a_opa_ff[31] ^ a_opb_ff[31];
   end

   // ---------------- stage C: clamp product, load divider ----------------
   sia_pkg::carry_type car_ff [0:sia_pkg::DIV_STEPS];
   sia_pkg::div_type   div_ff [0:sia_pkg::DIV_STEPS];
   logic               vld_ff [0:sia_pkg::DIV_STEPS];
   sia_pkg::carry_type c_car_in;

   always_comb begin
      c_car_in.fast_result = (b_cmd_ff == sia_pkg::CMD_MUL) ? sia_pkg::sat64(b_prod_ff)
                                                            : b_res_ff;
      c_car_in.is_null  = b_null_ff;
      c_car_in.is_div   = (b_cmd_ff == sia_pkg::CMD_DIV);
      c_car_in.div_zero = (b_abs_b_ff == 32'd0);
      c_car_in.negate   = b_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= b_vld_ff;
      car_ff[0]     <= c_car_in;
      div_ff[0].rem <= 32'd0;
      div_ff[0].dvd <= b_abs_a_ff;
      div_ff[0].dsr <= b_abs_b_ff;
   end

   // ---------------- divider: one restoring step a stage ----------------
   for (genvar k = 0; k < sia_pkg::DIV_STEPS; k++) begin : g_div
      logic [32:0]       shifted_in;
      logic [32:0]       trial_in;
      sia_pkg::div_type  next_in;

      always_comb begin
         shifted_in = {div_ff[k].rem, div_ff[k].dvd[31]};
         trial_in   = shifted_in - {1'b0, div_ff[k].dsr};
         next_in.dsr = div_ff[k].dsr;
         if (!trial_in[32]) begin
            next_in.rem = trial_in[31:0];
            next_in.dvd = {div_ff[k].dvd[30:0], 1'b1};
         end else begin
            next_in.rem = shifted_in[31:0];
            next_in.dvd = {div_ff[k].dvd[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else vld_ff[k+1] <= vld_ff[k];
         car_ff[k+1] <= car_ff[k];
         div_ff[k+1] <= next_in;
      end
   end

   // ---------------- output stage: sign, clamp, select ----------------
   sia_pkg::carry_type end_car;
   logic [31:0]        quo;
   logic [31:0]        out_res_in;
   logic               out_status_in;

   always_comb begin
      end_car = car_ff[sia_pkg::DIV_STEPS];
      quo     = div_ff[sia_pkg::DIV_STEPS].dvd;
      out_status_in = 1'b0;
      if (!end_car.is_div) out_res_in = end_car.fast_result;
      else if (end_car.div_zero) begin
         out_res_in    = 32'd0;
         out_status_in = 1'b1;
      end else if (end_car.negate) out_res_in = ~quo + 32'd1;
      else if (quo[31]) out_res_in = sia_pkg::INT_MAX; // minimum over minus one
      else out_res_in = quo;
   end

   logic        out_vld_ff;
   logic [31:0] out_res_ff;
   logic        out_null_ff;
   logic        out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= vld_ff[sia_pkg::DIV_STEPS];
      out_res_ff    <= out_res_in;
      out_null_ff   <= end_car.is_null;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result         = out_res_ff;
   assign rsp_result_is_null = out_null_ff;
   assign rsp_status         = out_status_ff;

   // ---------------- checks ----------------
   `SIA_ASSERT_NOW(a_div_zero_clean, rsp_valid && rsp_status, rsp_result == 32'd0 && !rsp_result_is_null)
   `SIA_ASSERT_NOW(a_null_zero, rsp_valid && rsp_result_is_null, rsp_result == 32'd0 && !rsp_status)
   `SIA_ASSERT_NEXT(a_stage_advance, a_vld_ff, b_vld_ff)
   `SIA_ASSERT_NEXT(a_div_advance, vld_ff[sia_pkg::DIV_STEPS], rsp_valid)

endmodule

/* tb/tb_saturating_int32_alu_core.sv */
`timescale 1ns / 1ps
module tb_saturating_int32_alu_core;

   localparam int LATENCY = 36;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS = 750;
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   // One expected response word.
   typedef struct {
      logic [31:0] result;
      logic        is_null;
      logic        status;
   } alu_word_type;

   // Scoreboard: predicts the clamped ALU response for each accepted
   // request and checks responses in order.
   class alu_scoreboard;
      alu_word_type pending[$];
      int           errors;

      function logic [31:0] clamp32(input longint v);
         if (v > longint'(32'sh7fff_ffff)) return sia_pkg::INT_MAX;
         if (v < -longint'(64'sd2147483648)) return sia_pkg::INT_MIN;
         return v[31:0];
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_request(input logic [2:0] cmd, input logic signed [31:0] a,
                                 input logic signed [31:0] b,
                                 input logic signed [63:0] w,
                                 input logic an, input logic bn);
         alu_word_type e;
         longint la, lb;
         la = a;
         lb = b;
         e.result = '0;
         e.is_null = 1'b0;
         e.status = 1'b0;
         case (cmd)
            sia_pkg::CMD_ADD: e.result = clamp32(la + lb);
            sia_pkg::CMD_SUB: e.result = clamp32(la - lb);
            sia_pkg::CMD_MUL: e.result = clamp32(la * lb);
            sia_pkg::CMD_DIV: begin
               // divide by zero flags status; quotient truncates toward zero
               if (lb == 0) e.status = 1'b1;
               else e.result = clamp32(la / lb);
            end
            sia_pkg::CMD_NARROW: begin
               if (w > longint'(32'sh7fff_ffff)) e.result = sia_pkg::INT_MAX;
               else if (w < -longint'(64'sd2147483648)) e.result = sia_pkg::INT_MIN;
               else e.result = w[31:0];
            end
            sia_pkg::CMD_SUM: begin
               // null flags: both null -> null, one null -> pass the other
               if (an && bn) e.is_null = 1'b1;
               else if (an) e.result = b;
               else if (bn) e.result = a;
               else e.result = clamp32(la + lb);
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      task check_response(input logic [31:0] r, input logic n, input logic s);
         alu_word_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected word result=%h", r));
            return;
         end
         e = pending.pop_front();
         if (r !== e.result)
            report_mismatch($sformatf("result %h exp %h", r, e.result));
         if (n !== e.is_null)
            report_mismatch($sformatf("is_null %b exp %b", n, e.is_null));
         if (s !== e.status)
            report_mismatch($sformatf("status %b exp %b", s, e.status));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_cmd;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic signed [63:0] req_wide_value;
   logic               req_a_is_null;
   logic               req_b_is_null;
   logic               rsp_valid;
   logic signed [31:0] rsp_result;
   logic               rsp_result_is_null;
   logic               rsp_status;

   alu_scoreboard alu_sb;
   int            idle_cycles = 0;

   saturating_int32_alu_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .req_wide_value     (req_wide_value),
      .req_a_is_null      (req_a_is_null),
      .req_b_is_null      (req_b_is_null),
      .rsp_valid          (rsp_valid),
      .rsp_result         (rsp_result),
      .rsp_result_is_null (rsp_result_is_null),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Monitor: request and response acceptance, plus the watchdog on
   // cycles where nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            alu_sb.note_request(req_cmd, req_operand_a, req_operand_b, req_wide_value,
                                req_a_is_null, req_b_is_null);
         if (rsp_valid)
            alu_sb.check_response(rsp_result, rsp_result_is_null, rsp_status);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Drive one word; start stays high across back-to-back words.
   task automatic send_word(input logic [2:0] cmd, input logic [31:0] a,
                            input logic [31:0] b, input logic [63:0] w,
                            input logic an, input logic bn);
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_operand_a  <= a;
      req_operand_b  <= b;
      req_wide_value <= w;
      req_a_is_null  <= an;
      req_b_is_null  <= bn;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // a zero-length gap leaves start high for the next word
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_operand();
      // bias toward edges so saturation and sign cases show up often
      case ($urandom_range(0, 7))
         0: return sia_pkg::INT_MAX;
         1: return sia_pkg::INT_MIN;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 15) - 8;
         5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_wide();
      case ($urandom_range(0, 5))
         0: return {{33{1'b0}}, 31'h7fff_ffff} + 64'($urandom_range(0, 2)) - 64'd1;
         1: return {{33{1'b1}}, 31'h0} + 64'($urandom_range(0, 2)) - 64'd1;
         2: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   initial begin
      int burst;
      logic [2:0] cmd;
      alu_sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_cmd = sia_pkg::CMD_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      req_wide_value = '0;
      req_a_is_null = 1'b0;
      req_b_is_null = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: saturation edges, divide corners, narrowing, null cases, spare commands
      send_word(sia_pkg::CMD_ADD, sia_pkg::INT_MAX, 32'd1, '0, 1'b1, 1'b1);
      send_word(sia_pkg::CMD_ADD, sia_pkg::INT_MIN, 32'hffff_ffff, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_SUB, sia_pkg::INT_MIN, 32'd1, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_SUB, sia_pkg::INT_MAX, sia_pkg::INT_MIN, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_MUL, sia_pkg::INT_MIN, sia_pkg::INT_MIN, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_MUL, sia_pkg::INT_MAX, 32'hffff_fffe, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_MUL, 32'hffff_fff9, 32'd6, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_DIV, 32'd77, 32'd0, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_DIV, sia_pkg::INT_MIN, 32'hffff_ffff, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_DIV, 32'hffff_fff9, 32'd2, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_DIV, sia_pkg::INT_MIN, sia_pkg::INT_MAX, '0, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_NARROW, '0, '0, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_NARROW, '0, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_NARROW, '0, '0, 64'h0000_0000_8000_0000, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_NARROW, '0, '0, 64'hffff_ffff_8000_0000, 1'b0, 1'b0);
      send_word(sia_pkg::CMD_SUM, 32'd5, 32'd9, '0, 1'b1, 1'b1);
      send_word(sia_pkg::CMD_SUM, 32'd5, 32'd9, '0, 1'b1, 1'b0);
      send_word(sia_pkg::CMD_SUM, 32'd5, 32'd9, '0, 1'b0, 1'b1);
      send_word(sia_pkg::CMD_SUM, sia_pkg::INT_MAX, sia_pkg::INT_MAX, '0, 1'b0, 1'b0);
      send_word(CMD_SPARE6, sia_pkg::INT_MAX, sia_pkg::INT_MAX, '1, 1'b1, 1'b1);
      send_word(CMD_SPARE7, sia_pkg::INT_MIN, 32'd3, '1, 1'b0, 1'b1);

      // hold off until the pipe drains once
      start <= 1'b0;
      while (alu_sb.pending.size() != 0) @(posedge clock);

      // random bursts with random gaps, some long unbroken stretches
      for (int n = 0; n < RANDOM_WORDS; ) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 12);
         for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) begin
            cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            send_word(cmd, rand_operand(),
                      ($urandom_range(0, 9) == 0) ? 32'd0 : rand_operand(),
                      rand_wide(), 1'($urandom), 1'($urandom));
         end
         pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 45));
      end

      start <= 1'b0;
      while (alu_sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (alu_sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

/* saturating_int32_alu_core.f */
+incdir+sv
sv/sia_pkg.sv
sv/saturating_int32_alu_core.sv
tb/tb_saturating_int32_alu_core.sv
